>>> design/dhvp_pkg.sv
// dhvp_pkg: shared types, character codes, name tables and token helpers
// for the date header value parser; used by dhvp_parser and the top level
`default_nettype none

package dhvp_pkg;

  localparam logic [13:0] NUM_MAX = 14'd16383;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [23:0] ZONE_GMT = 24'h474D54;

  localparam int N_DAYS   = 7;
  localparam int N_MONTHS = 12;

  localparam logic [23:0] DAY_NAMES [N_DAYS] = '{
    24'h4D6F6E, 24'h547565, 24'h576564, 24'h546875,
    24'h467269, 24'h536174, 24'h53756E
  };

  localparam logic [23:0] MONTH_NAMES [N_MONTHS] = '{
    24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072,
    24'h4D6179, 24'h4A756E, 24'h4A756C, 24'h417567,
    24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
  };

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_FORMAT    = 4'd1,
    ST_WEEKDAY   = 4'd2,
    ST_DAY       = 4'd3,
    ST_MONTH     = 4'd4,
    ST_YEAR_LEN  = 4'd5,
    ST_HOUR      = 4'd6,
    ST_MINUTE    = 4'd7,
    ST_SECOND    = 4'd8,
    ST_ZONE      = 4'd9
  } status_t;

  typedef enum logic [8:0] {
    PH_WEEKDAY = 9'b000000001,
    PH_SPACE   = 9'b000000010,
    PH_DAY     = 9'b000000100,
    PH_MONTH   = 9'b000001000,
    PH_YEAR    = 9'b000010000,
    PH_HOUR    = 9'b000100000,
    PH_MINUTE  = 9'b001000000,
    PH_SECOND  = 9'b010000000,
    PH_ZONE    = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  week_day;
    logic [4:0]  day_of_month;
    logic [3:0]  month_index;
    logic [13:0] year_value;
    logic [4:0]  hour_value;
    logic [5:0]  minute_value;
    logic [5:0]  second_value;
  } out_t;

  typedef struct packed {
    logic [2:0]  len;
    logic [23:0] name;
    logic [13:0] acc;
    logic        done;
  } tok_t;

  localparam tok_t TOK_CLEAR = '0;

  // append one byte to the current token, accumulating leading digits
  function automatic tok_t take_byte(tok_t t, logic [7:0] b);
    tok_t        r;
    logic [17:0] prod;
    r = t;
    if (t.len != 3'd7) begin
      r.len = t.len + 3'd1;
    end
    r.name = {t.name[15:0], b};
    prod = ({4'b0, t.acc} * 18'd10) + {14'b0, b[3:0]};
    if (!t.done) begin
      if (b inside {[CH_ZERO:CH_NINE]}) begin
        r.acc = (prod > {4'b0, NUM_MAX}) ? NUM_MAX : prod[13:0];
      end else begin
        r.done = 1'b1;
      end
    end
    return r;
  endfunction

  // returns N_DAYS when no weekday name matches
  function automatic logic [2:0] find_day(tok_t t);
    logic [2:0] r;
    r = 3'(N_DAYS);
    for (int i = N_DAYS - 1; i >= 0; i--) begin
      if (t.len == 3'd3 && t.name == DAY_NAMES[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  // returns N_MONTHS when no month name matches
  function automatic logic [3:0] find_month(tok_t t);
    logic [3:0] r;
    r = 4'(N_MONTHS);
    for (int i = N_MONTHS - 1; i >= 0; i--) begin
      if (t.len == 3'd3 && t.name == MONTH_NAMES[i]) begin
        r = 4'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/dhvp_parser.sv
// dhvp_parser: per-byte token state machine with saved fields and latched error
// depends on dhvp_pkg
`default_nettype none

module dhvp_parser
  import dhvp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire in_t  item,
  output out_t      res
);

  phase_t      phase_r, phase_nxt;
  tok_t        tok_r, tok_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [13:0] year_r, year_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [3:0]  err_r, err_nxt;

  logic [7:0]  b;
  logic [2:0]  day_idx;
  logic [3:0]  mon_idx;
  tok_t        tok_take;

  assign b        = item.in_byte;
  assign day_idx  = find_day(tok_r);
  assign mon_idx  = find_month(tok_r);
  assign tok_take = take_byte(tok_r, b);

  always_comb begin
    phase_nxt  = phase_r;
    tok_nxt    = tok_r;
    wday_nxt   = wday_r;
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    err_nxt    = err_r;
    if (err_r == ST_OK) begin
      if (phase_r == PH_ZONE) begin
        tok_nxt.len  = tok_take.len;
        tok_nxt.name = tok_take.name;
        if (item.in_last && (tok_take.len != 3'd3 || tok_take.name != ZONE_GMT)) begin
          err_nxt = ST_ZONE;
        end
      end else begin
        case (phase_r)
          PH_WEEKDAY: begin
            if (b == CH_COMMA) begin
              if (day_idx == 3'(N_DAYS)) begin
                err_nxt = ST_WEEKDAY;
              end else begin
                wday_nxt  = day_idx;
                tok_nxt   = TOK_CLEAR;
                phase_nxt = PH_SPACE;
              end
            end else begin
              tok_nxt = tok_take;
            end
          end
          PH_SPACE: begin
            if (b != CH_SPACE) begin
              err_nxt = ST_FORMAT;
            end else begin
              phase_nxt = PH_DAY;
            end
          end
          PH_DAY: begin
            if (b == CH_SPACE) begin
              if (tok_r.acc > 14'd31) begin
                err_nxt = ST_DAY;
              end else begin
                day_nxt   = tok_r.acc[4:0];
                tok_nxt   = TOK_CLEAR;
                phase_nxt = PH_MONTH;
              end
            end else begin
              tok_nxt = tok_take;
            end
          end
          PH_MONTH: begin
            if (b == CH_SPACE) begin
              if (mon_idx == 4'(N_MONTHS)) begin
                err_nxt = ST_MONTH;
              end else begin
                month_nxt = mon_idx;
                tok_nxt   = TOK_CLEAR;
                phase_nxt = PH_YEAR;
              end
            end else begin
              tok_nxt = tok_take;
            end
          end
          PH_YEAR: begin
            if (b == CH_SPACE) begin
              if (tok_r.len != 3'd4) begin
                err_nxt = ST_YEAR_LEN;
              end else begin
                year_nxt  = tok_r.acc;
                tok_nxt   = TOK_CLEAR;
                phase_nxt = PH_HOUR;
              end
            end else begin
              tok_nxt = tok_take;
            end
          end
          PH_HOUR: begin
            if (b == CH_COLON) begin
              if (tok_r.acc >= 14'd24) begin
                err_nxt = ST_HOUR;
              end else begin
                hour_nxt  = tok_r.acc[4:0];
                tok_nxt   = TOK_CLEAR;
                phase_nxt = PH_MINUTE;
              end
            end else begin
              tok_nxt = tok_take;
            end
          end
          PH_MINUTE: begin
            if (b == CH_COLON) begin
              if (tok_r.acc >= 14'd60) begin
                err_nxt = ST_MINUTE;
              end else begin
                minute_nxt = tok_r.acc[5:0];
                tok_nxt    = TOK_CLEAR;
                phase_nxt  = PH_SECOND;
              end
            end else begin
              tok_nxt = tok_take;
            end
          end
          PH_SECOND: begin
            if (b == CH_SPACE) begin
              if (tok_r.acc >= 14'd60) begin
                err_nxt = ST_SECOND;
              end else begin
                // seconds stay in the accumulator through the zone
                tok_nxt.len  = 3'd0;
                tok_nxt.name = 24'd0;
                tok_nxt.done = 1'b1;
                phase_nxt    = PH_ZONE;
              end
            end else begin
              tok_nxt = tok_take;
            end
          end
          default: begin
            err_nxt = ST_FORMAT;
          end
        endcase
        if (item.in_last && err_nxt == ST_OK) begin
          err_nxt = ST_FORMAT;
        end
      end
    end
  end

  always_comb begin
    res        = '0;
    res.status = err_nxt;
    if (err_nxt == ST_OK) begin
      res.week_day     = wday_nxt;
      res.day_of_month = day_nxt;
      res.month_index  = month_nxt;
      res.year_value   = year_nxt;
      res.hour_value   = hour_nxt;
      res.minute_value = minute_nxt;
      res.second_value = tok_nxt.acc[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.in_last)) begin
      phase_r  <= PH_WEEKDAY;
      tok_r    <= TOK_CLEAR;
      wday_r   <= '0;
      day_r    <= '0;
      month_r  <= '0;
      year_r   <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      err_r    <= ST_OK;
    end else if (step) begin
      phase_r  <= phase_nxt;
      tok_r    <= tok_nxt;
      wday_r   <= wday_nxt;
      day_r    <= day_nxt;
      month_r  <= month_nxt;
      year_r   <= year_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/date_header_value_parser.sv
// date_header_value_parser: top level, parser state plus registered result stage
// depends on dhvp_pkg and dhvp_parser
//
// Parses a date header value such as "Thu, 21 Feb 2002 13:02:03 GMT", one byte
// per transaction, and returns one result transaction (status and decoded
// fields) for the byte flagged in_last; earlier bytes return nothing. A byte is
// taken every clock: the parser state registers update in the cycle the byte is
// accepted, and for the last byte the result is captured into the output register
// in that same cycle. The input stalls only while a result sits in the output
// register and out_ready is low. The first error is latched and reported on the
// last byte; all decoded fields are zero whenever status is not ok. After the
// last byte the parser returns to its reset state, ready for the next value.
`default_nettype none

module date_header_value_parser
  import dhvp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic in_fire;
  out_t res;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  dhvp_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_fire),
    .item  (in_data),
    .res   (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && in_data.in_last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.in_last) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> sim/dhvp_checker.sv
// dhvp_checker: watches both channels of date_header_value_parser, predicts the
// result transaction of every date value and compares it field by field
// depends on dhvp_pkg for the transaction types and character codes
`timescale 1ns / 1ps

module dhvp_checker
  import dhvp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  wire in_t  in_data,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  wire out_t out_data,
  output int        mismatch_count,
  output int        dates_pending
);

  localparam string DAY_LIST   = "MonTueWedThuFriSatSun";
  localparam string MONTH_LIST = "JanFebMarAprMayJunJulAugSepOctNovDec";

  phase_t      ph;
  logic [2:0]  tlen;
  logic [23:0] tname;
  logic [13:0] tacc;
  logic        tdone;
  logic [2:0]  wd;
  logic [4:0]  dd;
  logic [3:0]  mo;
  logic [13:0] yr;
  logic [4:0]  hr;
  logic [5:0]  mi;
  status_t     err;
  out_t        date_q[$];

  initial begin
    mismatch_count = 0;
    dates_pending  = 0;
  end

  task automatic drop_token();
    tlen  = '0;
    tname = '0;
    tacc  = '0;
    tdone = 1'b0;
  endtask

  task automatic restart();
    ph  = PH_WEEKDAY;
    drop_token();
    wd  = '0;
    dd  = '0;
    mo  = '0;
    yr  = '0;
    hr  = '0;
    mi  = '0;
    err = ST_OK;
  endtask

  // index of the name equal to the current three character token, else the count
  function automatic int lookup_name(string names);
    int hit;
    hit = names.len() / 3;
    if (tlen == 3'd3) begin
      for (int i = names.len() / 3 - 1; i >= 0; i--) begin
        if (tname == {names[3*i], names[3*i+1], names[3*i+2]}) begin
          hit = i;
        end
      end
    end
    return hit;
  endfunction

  task automatic absorb_char(logic [7:0] b);
    int v;
    if (tlen != 3'd7) begin
      tlen++;
    end
    tname = {tname[15:0], b};
    if (!tdone) begin
      if (b >= CH_ZERO && b <= CH_NINE) begin
        v = int'(tacc) * 10 + int'(b - CH_ZERO);
        tacc = (v > int'(NUM_MAX)) ? NUM_MAX : 14'(v);
      end else begin
        tdone = 1'b1;
      end
    end
  endtask

  task automatic scan_char(logic [7:0] b);
    int idx;
    case (ph)
      PH_WEEKDAY: begin
        if (b == CH_COMMA) begin
          idx = lookup_name(DAY_LIST);
          if (idx >= 7) begin
            err = ST_WEEKDAY;
          end else begin
            wd = 3'(idx);
            drop_token();
            ph = PH_SPACE;
          end
        end else begin
          absorb_char(b);
        end
      end
      PH_SPACE: begin
        if (b != CH_SPACE) begin
          err = ST_FORMAT;
        end else begin
          ph = PH_DAY;
        end
      end
      PH_DAY: begin
        if (b == CH_SPACE) begin
          if (tacc > 14'd31) begin
            err = ST_DAY;
          end else begin
            dd = tacc[4:0];
            drop_token();
            ph = PH_MONTH;
          end
        end else begin
          absorb_char(b);
        end
      end
      PH_MONTH: begin
        if (b == CH_SPACE) begin
          idx = lookup_name(MONTH_LIST);
          if (idx >= 12) begin
            err = ST_MONTH;
          end else begin
            mo = 4'(idx);
            drop_token();
            ph = PH_YEAR;
          end
        end else begin
          absorb_char(b);
        end
      end
      PH_YEAR: begin
        if (b == CH_SPACE) begin
          if (tlen != 3'd4) begin
            err = ST_YEAR_LEN;
          end else begin
            yr = tacc;
            drop_token();
            ph = PH_HOUR;
          end
        end else begin
          absorb_char(b);
        end
      end
      PH_HOUR: begin
        if (b == CH_COLON) begin
          if (tacc >= 14'd24) begin
            err = ST_HOUR;
          end else begin
            hr = tacc[4:0];
            drop_token();
            ph = PH_MINUTE;
          end
        end else begin
          absorb_char(b);
        end
      end
      PH_MINUTE: begin
        if (b == CH_COLON) begin
          if (tacc >= 14'd60) begin
            err = ST_MINUTE;
          end else begin
            mi = tacc[5:0];
            drop_token();
            ph = PH_SECOND;
          end
        end else begin
          absorb_char(b);
        end
      end
      PH_SECOND: begin
        if (b == CH_SPACE) begin
          if (tacc >= 14'd60) begin
            err = ST_SECOND;
          end else begin
            // seconds stay in the accumulator while the zone is collected
            tlen  = '0;
            tname = '0;
            tdone = 1'b1;
            ph    = PH_ZONE;
          end
        end else begin
          absorb_char(b);
        end
      end
      default: begin
        err = ST_FORMAT;
      end
    endcase
  endtask

  task automatic step_char(logic [7:0] b, logic last);
    out_t res;
    if (err == ST_OK) begin
      if (ph == PH_ZONE) begin
        if (tlen != 3'd7) begin
          tlen++;
        end
        tname = {tname[15:0], b};
        if (last && (tlen != 3'd3 || tname != ZONE_GMT)) begin
          err = ST_ZONE;
        end
      end else begin
        scan_char(b);
        if (last && err == ST_OK) begin
          err = ST_FORMAT;
        end
      end
    end
    if (last) begin
      res = '0;
      res.status = err;
      if (err == ST_OK) begin
        res.week_day     = wd;
        res.day_of_month = dd;
        res.month_index  = mo;
        res.year_value   = yr;
        res.hour_value   = hr;
        res.minute_value = mi;
        res.second_value = tacc[5:0];
      end
      date_q.push_back(res);
      restart();
    end
  endtask

  task automatic note_field(string field, int want, int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      restart();
      date_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (date_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result transaction expected none actual status %0d",
                   $time, out_data.status);
        end else begin
          want = date_q.pop_front();
          note_field("status", want.status, out_data.status);
          note_field("week_day", want.week_day, out_data.week_day);
          note_field("day_of_month", want.day_of_month, out_data.day_of_month);
          note_field("month_index", want.month_index, out_data.month_index);
          note_field("year_value", want.year_value, out_data.year_value);
          note_field("hour_value", want.hour_value, out_data.hour_value);
          note_field("minute_value", want.minute_value, out_data.minute_value);
          note_field("second_value", want.second_value, out_data.second_value);
        end
      end
      if (in_valid && in_ready) begin
        step_char(in_data.in_byte, in_data.in_last);
      end
    end
    dates_pending <= date_q.size();
  end

endmodule

>>> sim/tb_top.sv
// tb_top: stimulus, handshake timing and verdict for date_header_value_parser
// depends on dhvp_pkg, the block itself and dhvp_checker
`timescale 1ns / 1ps

module tb_top;
  import dhvp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BYTE_TARGET    = 1360;
  localparam int HOLD_OFF       = 300;

  localparam string DAY_LIST   = "MonTueWedThuFriSatSun";
  localparam string MONTH_LIST = "JanFebMarAprMayJunJulAugSepOctNovDec";
  localparam string DELIMS     = ", :";

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;
  int   mismatch_count;
  int   dates_pending;
  int   idle_cycles = 0;

  logic [7:0] text_q[$];
  string      odd_zones[6] = '{"GM", "GMTT", "UTC", "gmt", "", "G T"};
  string      warmup[4]    = '{",", "Q", "Sun,x", "Tue, 32 "};

  date_header_value_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  dhvp_checker date_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .dates_pending  (dates_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic string num_text(int v, int width);
    string s;
    s = $sformatf("%0d", v);
    while (s.len() < width) begin
      s = {"0", s};
    end
    return s;
  endfunction

  function automatic int pick_bound(int lo, int hi);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) begin
      return lo;
    end else if (r == 1) begin
      return hi;
    end
    return $urandom_range(lo, hi);
  endfunction

  function automatic string mangle_name(string good);
    case ($urandom_range(0, 3))
      0: return good.tolower();
      1: return good.substr(0, 1);
      2: return {good, "s"};
      default: return $sformatf("%c%c%c", $urandom_range(65, 90),
                                $urandom_range(97, 122), $urandom_range(97, 122));
    endcase
  endfunction

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
    end
  endtask

  // well-formed dates, dates with one or more bad fields, corrupted or truncated dates, noise
  task automatic compose_value(int serial);
    int    kind;
    int    k;
    string wd_s, day_s, mo_s, yr_s, hr_s, mi_s, se_s, zone_s, gap_s;
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      k = $urandom_range(1, 12);
      repeat (k) begin
        if ($urandom_range(0, 2) == 0) begin
          text_q.push_back(DELIMS[$urandom_range(0, 2)]);
        end else begin
          text_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      return;
    end
    wd_s   = DAY_LIST.substr(3 * (serial % 7), 3 * (serial % 7) + 2);
    mo_s   = MONTH_LIST.substr(3 * (serial % 12), 3 * (serial % 12) + 2);
    gap_s  = " ";
    day_s  = num_text(pick_bound(0, 31), $urandom_range(1, 2));
    yr_s   = num_text(pick_bound(0, 9999), 4);
    hr_s   = num_text(pick_bound(0, 23), 2);
    mi_s   = num_text(pick_bound(0, 59), 2);
    se_s   = num_text(pick_bound(0, 59), 2);
    zone_s = "GMT";
    if ($urandom_range(0, 7) == 0) begin
      day_s = {day_s, "x"};
    end
    if ($urandom_range(0, 7) == 0) begin
      yr_s = {num_text($urandom_range(0, 99), 2), "ab"};
    end
    if ($urandom_range(0, 7) == 0) begin
      mi_s = {mi_s, "?"};
    end
    if (kind >= 55 && kind < 75) begin
      case ($urandom_range(0, 9))
        0: wd_s = mangle_name(wd_s);
        1: gap_s = ($urandom_range(0, 1) == 0) ? "" : "-";
        2: day_s = num_text($urandom_range(32, 99999), 0);
        3: mo_s = mangle_name(mo_s);
        4: begin
          k = $urandom_range(0, 2);
          yr_s = (k == 0) ? num_text($urandom_range(0, 999), 3) :
                 (k == 1) ? num_text($urandom_range(10000, 99999), 0) : "";
        end
        5: hr_s = num_text($urandom_range(24, 99999), 0);
        6: mi_s = num_text($urandom_range(60, 99), 0);
        7: se_s = num_text($urandom_range(60, 99999), 0);
        8: zone_s = odd_zones[$urandom_range(0, 5)];
        default: begin
          day_s = {"x", day_s};
          hr_s  = "";
        end
      endcase
    end
    put_str({wd_s, ",", gap_s, day_s, " ", mo_s, " ", yr_s, " ",
             hr_s, ":", mi_s, ":", se_s, " ", zone_s});
    if (kind >= 75) begin
      k = $urandom_range(0, text_q.size() - 1);
      if ($urandom_range(0, 1) == 0) begin
        text_q[k] = 8'($urandom_range(0, 255));
      end else begin
        while (text_q.size() > k + 1) begin
          void'(text_q.pop_back());
        end
      end
    end
  endtask

  task automatic send_value();
    int gap;
    bit calm;
    calm = ($urandom_range(0, 3) == 0);
    foreach (text_q[i]) begin
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= in_t'{text_q[i], i == text_q.size() - 1};
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
  endtask

  initial begin
    int stall;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    wait (rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (taken == 8) begin
        stall = HOLD_OFF;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if ($urandom_range(0, 9) == 0) begin
        calm = !calm;
      end
    end
  end

  initial begin
    int sent;
    int serial;
    sent   = 0;
    serial = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (warmup[i]) begin
      text_q.delete();
      put_str(warmup[i]);
      send_value();
    end
    text_q = '{8'h00, 8'hFF};
    send_value();
    while (sent < BYTE_TARGET) begin
      compose_value(serial);
      serial++;
      sent += text_q.size();
      send_value();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (dates_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/dhvp_pkg.sv
design/dhvp_parser.sv
design/date_header_value_parser.sv
sim/dhvp_checker.sv
sim/tb_top.sv
